@@ hdl/dpcs_pkg.sv @@
// Shared types and constants of the depth-to-point-cloud sampler.
package dpcs_pkg;

   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;

   // Widest row or column index the parameters allow (4096 entries).
   localparam int POS_W = 12;
   localparam int COORD_W = 29;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] STRIDE_NEAR = 4'd3;
   localparam logic [3:0] STRIDE_MID = 4'd8;
   localparam logic [3:0] STRIDE_FAR = 4'd15;
   localparam logic [15:0] NEAR_LIMIT_MM = 16'd100;
   localparam logic [9:0] DEF_ROW_START = 10'd240;

   localparam logic [2:0] REG_FOCAL_X = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_X = 3'd2;
   localparam logic [2:0] REG_CENTER_Y = 3'd3;
   localparam logic [2:0] REG_FAR_LIMIT = 3'd4;
   localparam logic [2:0] REG_ROW_START = 3'd5;
   localparam logic [2:0] REG_ZONE_MID = 3'd6;
   localparam logic [2:0] REG_ZONE_FAR = 3'd7;

   typedef struct packed {
      logic [15:0] focal_x;
      logic [15:0] focal_y;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] far_limit_mm;
      logic [9:0] row_start;
      logic [9:0] row_zone_mid;
      logic [9:0] row_zone_far;
   } csr_type;

   typedef struct packed {
      logic [15:0] depth_mm;
      logic [15:0] cost;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [15:0] frame;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ hdl/dpcs_front.sv @@
// Pixel front end: raster counters, sampling grid and point screening.
module dpcs_front
   import dpcs_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic clock,
   input  logic reset,
   input  csr_type csr,
   input  logic accept,
   input  logic [15:0] depth_mm,
   input  logic [15:0] cost,
   input  logic last_of_row,
   input  logic last_of_frame,
   output logic push,
   output job_type job
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int NCW = CW + 1;
   localparam int NRW = (RW + 1 > 10) ? RW + 1 : 10;

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [NRW-1:0] nrow_ff, nrow_in;
   logic [NCW-1:0] ncol_ff, ncol_in;
   logic [3:0] stride_ff, stride_in;
   logic [15:0] frame_ff, frame_in;

   logic [3:0] stride;
   logic row_hit, col_hit, good;
   logic [NCW:0] col_sum, col_cap;
   logic [NRW:0] row_sum, row_cap;

   always_comb begin
      priority if (13'(row_ff) >= 13'(csr.row_zone_far)) begin
         stride = STRIDE_FAR;
      end else if (13'(row_ff) >= 13'(csr.row_zone_mid)) begin
         stride = STRIDE_MID;
      end else begin
         stride = stride_ff;
      end
   end

   assign row_hit = (NRW'(row_ff) == nrow_ff);
   assign col_hit = (NCW'(col_ff) == ncol_ff);
   assign good = !(depth_mm > csr.far_limit_mm || depth_mm < NEAR_LIMIT_MM || cost == 16'd0);
   assign col_sum = (NCW+1)'(ncol_ff) + (NCW+1)'(stride);
   assign col_cap = (NCW+1)'(2 * MAX_COLS - 1);
   assign row_sum = (NRW+1)'(nrow_ff) + (NRW+1)'(stride);
   assign row_cap = (NRW+1)'(2 * MAX_ROWS - 1);

   assign push = accept && row_hit && col_hit && good;
   assign job.depth_mm = depth_mm;
   assign job.cost = cost;
   assign job.row = POS_W'(row_ff);
   assign job.col = POS_W'(col_ff);
   assign job.frame = frame_ff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      nrow_in = nrow_ff;
      ncol_in = ncol_ff;
      stride_in = stride_ff;
      frame_in = frame_ff;
      if (accept) begin
         if (row_hit && col_hit) begin
            ncol_in = (col_sum > col_cap) ? NCW'(col_cap) : NCW'(col_sum);
         end
         priority if (last_of_frame) begin
            frame_in = frame_ff + 16'd1;
            row_in = '0;
            col_in = '0;
            nrow_in = NRW'(csr.row_start);
            ncol_in = '0;
            stride_in = STRIDE_NEAR;
         end else if (last_of_row) begin
            if (row_hit) begin
               nrow_in = (row_sum > row_cap) ? NRW'(row_cap) : NRW'(row_sum);
               stride_in = stride;
            end
            if (row_ff < RW'(MAX_ROWS - 1)) begin
               row_in = row_ff + 1'b1;
            end
            col_in = '0;
            ncol_in = '0;
         end else begin
            if (col_ff < CW'(MAX_COLS - 1)) begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         nrow_ff <= NRW'(DEF_ROW_START);
         ncol_ff <= '0;
         stride_ff <= STRIDE_NEAR;
         frame_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         nrow_ff <= nrow_in;
         ncol_ff <= ncol_in;
         stride_ff <= stride_in;
         frame_ff <= frame_in;
      end
   end

endmodule

@@ hdl/dpcs_fifo.sv @@
// Short request queue between the front end and the projection unit.
module dpcs_fifo
   import dpcs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  job_type push_job,
   input  logic pop,
   output job_type pop_job,
   output qstat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;

   assign stat.full = (cnt_ff == (AW+1)'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_job = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/dpcs_back.sv @@
// Projection unit: offset multiply, bit-serial divide, saturate, result register.
module dpcs_back
   import dpcs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  csr_type csr,
   input  qstat_type qstat,
   input  job_type qjob,
   output logic pop,
   output logic busy_div,
   output logic [5:0] div_count,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x_mm,
   output logic signed [COORD_W-1:0] rsp_point_y_mm,
   output logic [15:0] rsp_point_z_mm,
   output logic [15:0] rsp_intensity,
   output logic [9:0] rsp_pixel_row,
   output logic [9:0] rsp_pixel_col,
   output logic [15:0] rsp_frame_number
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL = 2'd1;
   localparam logic [1:0] S_DIV = 2'd2;
   localparam logic [1:0] S_OUT = 2'd3;
   localparam logic [5:0] DIV_STEPS = 6'd32;

   logic [1:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   job_type job_ff;
   logic neg_ff [2];
   logic [31:0] quo_ff [2];
   logic [15:0] rem_ff [2];
   logic neg_in [2];
   logic [31:0] quo_in [2];
   logic [15:0] rem_in [2];
   logic [15:0] focal [2];
   logic [15:0] center [2];
   logic [15:0] pos [2];
   logic signed [16:0] off [2];
   logic signed [33:0] prod [2];
   logic [16:0] trial [2];
   logic [COORD_W-1:0] coord [2];
   logic out_valid_ff;
   logic load_out;

   function automatic logic [COORD_W-1:0] saturate(input logic neg, input logic [31:0] mag);
      logic [31:0] lim;
      lim = 32'(1) << (COORD_W - 1);
      if (neg) begin
         saturate = (mag > lim) ? COORD_W'(lim) : COORD_W'(-mag);
      end else begin
         saturate = (mag > lim - 32'd1) ? COORD_W'(lim - 32'd1) : COORD_W'(mag);
      end
   endfunction

   assign focal[0] = csr.focal_x;
   assign focal[1] = csr.focal_y;
   assign center[0] = csr.center_x;
   assign center[1] = csr.center_y;
   assign pos[0] = 16'({job_ff.col, 4'b0000});
   assign pos[1] = 16'({job_ff.row, 4'b0000});

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         off[l] = $signed({1'b0, pos[l]}) - $signed({1'b0, center[l]});
         prod[l] = off[l] * $signed({1'b0, job_ff.depth_mm});
         trial[l] = {rem_ff[l], quo_ff[l][31]};
         coord[l] = (focal[l] == 16'd0) ? '0 : saturate(neg_ff[l], quo_ff[l]);
      end
   end

   assign pop = (state_ff == S_IDLE) && !qstat.empty;
   assign load_out = (state_ff == S_OUT) && (!out_valid_ff || !rsp_stall);
   assign busy_div = (state_ff == S_DIV);
   assign div_count = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      for (int l = 0; l < 2; l++) begin
         neg_in[l] = neg_ff[l];
         quo_in[l] = quo_ff[l];
         rem_in[l] = rem_ff[l];
      end
      unique case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            for (int l = 0; l < 2; l++) begin
               neg_in[l] = prod[l][33];
               quo_in[l] = prod[l][33] ? 32'(-prod[l]) : 32'(prod[l]);
               rem_in[l] = '0;
            end
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int l = 0; l < 2; l++) begin
               if (trial[l] >= {1'b0, focal[l]}) begin
                  rem_in[l] = 16'(trial[l] - {1'b0, focal[l]});
                  quo_in[l] = {quo_ff[l][30:0], 1'b1};
               end else begin
                  rem_in[l] = trial[l][15:0];
                  quo_in[l] = {quo_ff[l][30:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_STEPS - 6'd1) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= qjob;
      end
      for (int l = 0; l < 2; l++) begin
         neg_ff[l] <= neg_in[l];
         quo_ff[l] <= quo_in[l];
         rem_ff[l] <= rem_in[l];
      end
      if (load_out) begin
         rsp_point_x_mm <= coord[0];
         rsp_point_y_mm <= coord[1];
         rsp_point_z_mm <= job_ff.depth_mm;
         rsp_intensity <= job_ff.cost;
         rsp_pixel_row <= 10'(job_ff.row);
         rsp_pixel_col <= 10'(job_ff.col);
         rsp_frame_number <= job_ff.frame;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ hdl/depth_to_point_cloud_sampler_top.sv @@
// Top level of the depth-to-point-cloud sampler.
//
//   port group | direction | handshake          | carries
//   req_*      | in        | req_valid/req_stall | depth, cost, row and frame marks
//   rsp_*      | out       | rsp_valid/rsp_stall | x, y, z, intensity, row, col, frame
//   csr_*      | in        | csr_valid/csr_ready | register index and write data
//
// The front end takes one pixel request per cycle while the point queue has room.
// Each point passes through the projection unit in order: a queue pop, a multiply
// state, a one-bit-per-cycle divider for x and y side by side, and a load into the
// result register, which waits while rsp_stall holds an untaken result. A new point
// is popped only after the last one is loaded. Pixels that give no point cost nothing.
// Reset is synchronous and clears counters, queue and result valid; registers return
// to their defaults. req_stall rises only while the queue is full.
module depth_to_point_cloud_sampler_top
   import dpcs_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [15:0] req_depth_mm,
   input  logic [15:0] req_cost,
   input  logic req_last_of_row,
   input  logic req_last_of_frame,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x_mm,
   output logic signed [COORD_W-1:0] rsp_point_y_mm,
   output logic [15:0] rsp_point_z_mm,
   output logic [15:0] rsp_intensity,
   output logic [9:0] rsp_pixel_row,
   output logic [9:0] rsp_pixel_col,
   output logic [15:0] rsp_frame_number,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data
);

   csr_type csr_ff;
   qstat_type qstat;
   job_type push_job, pop_job;
   logic accept, push, pop, busy_div;
   logic [5:0] div_count;

   // Registers are always writable; software must write them only while idle (not enforced here).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.focal_x <= 16'd6800;
         csr_ff.focal_y <= 16'd6800;
         csr_ff.center_x <= 16'd6768;
         csr_ff.center_y <= 16'd3824;
         csr_ff.far_limit_mm <= 16'd6000;
         csr_ff.row_start <= DEF_ROW_START;
         csr_ff.row_zone_mid <= 10'd320;
         csr_ff.row_zone_far <= 10'd360;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FOCAL_X: csr_ff.focal_x <= csr_data;
            REG_FOCAL_Y: csr_ff.focal_y <= csr_data;
            REG_CENTER_X: csr_ff.center_x <= csr_data;
            REG_CENTER_Y: csr_ff.center_y <= csr_data;
            REG_FAR_LIMIT: csr_ff.far_limit_mm <= csr_data;
            REG_ROW_START: csr_ff.row_start <= csr_data[9:0];
            REG_ZONE_MID: csr_ff.row_zone_mid <= csr_data[9:0];
            REG_ZONE_FAR: csr_ff.row_zone_far <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // Hold requests only while the queue cannot take another point.
   assign req_stall = qstat.full;
   assign accept = req_valid && !req_stall;

   dpcs_front #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr(csr_ff),
      .accept(accept),
      .depth_mm(req_depth_mm),
      .cost(req_cost),
      .last_of_row(req_last_of_row),
      .last_of_frame(req_last_of_frame),
      .push(push),
      .job(push_job)
   );

   dpcs_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_job(push_job),
      .pop(pop),
      .pop_job(pop_job),
      .stat(qstat)
   );

   dpcs_back u_back (
      .clock(clock),
      .reset(reset),
      .csr(csr_ff),
      .qstat(qstat),
      .qjob(pop_job),
      .pop(pop),
      .busy_div(busy_div),
      .div_count(div_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point_x_mm(rsp_point_x_mm),
      .rsp_point_y_mm(rsp_point_y_mm),
      .rsp_point_z_mm(rsp_point_z_mm),
      .rsp_intensity(rsp_intensity),
      .rsp_pixel_row(rsp_pixel_row),
      .rsp_pixel_col(rsp_pixel_col),
      .rsp_frame_number(rsp_frame_number)
   );

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("point pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("point popped from empty queue");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      busy_div |-> div_count < 6'd32) else $error("divider overran its steps");
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid) else $error("result valid right after reset");
`endif

endmodule
